>>> hdl/sdma_pkg.sv
// ----------------------------------------------------------------------------
// Slow-data message assembler package
// Shared types and constants: frame layout, message layout, sync and key
// bytes, and the step numbers of the frame sequence.
// ----------------------------------------------------------------------------
`default_nettype none

package sdma_pkg;

	localparam int unsigned MsgChars    = 20;
	localparam int unsigned StoredChars = 17;

	localparam logic [7:0] SYNC_A    = 8'h55;
	localparam logic [7:0] SYNC_B    = 8'h2d;
	localparam logic [7:0] SYNC_C    = 8'h16;
	localparam logic [7:0] KEY_A     = 8'h70;
	localparam logic [7:0] KEY_B     = 8'h4f;
	localparam logic [7:0] KEY_C     = 8'h93;
	localparam logic [7:0] MARK_BASE = 8'h30;

	localparam logic [7:0] FC_SYNC = 8'h00;

	localparam logic [3:0] STEP_IDLE  = 4'd0;
	localparam logic [3:0] STEP_FIRST = 4'd1;
	localparam logic [3:0] STEP_2     = 4'd2;
	localparam logic [3:0] STEP_3     = 4'd3;
	localparam logic [3:0] STEP_4     = 4'd4;
	localparam logic [3:0] STEP_5     = 4'd5;
	localparam logic [3:0] STEP_6     = 4'd6;
	localparam logic [3:0] STEP_7     = 4'd7;
	localparam logic [3:0] STEP_LAST  = 4'd8;

	// One received frame; frame_control sits in the lowest bits.
	typedef struct packed {
		logic [7:0] slow_byte_c;
		logic [7:0] slow_byte_b;
		logic [7:0] slow_byte_a;
		logic [7:0] frame_control;
	} frame_t;

	// One assembled message; text_low sits in the lowest bits.
	typedef struct packed {
		logic [31:0] text_high;
		logic [63:0] text_mid;
		logic [63:0] text_low;
	} msg_t;

endpackage

`default_nettype wire

>>> hdl/sdma_in_reg.sv
// ----------------------------------------------------------------------------
// Slow-data message assembler input register
// Holds one frame for the assembler; takes a new item whenever the held one
// is empty or leaves in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdma_in_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	output logic               s_tready,
	input  wire  [31:0]        s_tdata,   // frame_control, slow_byte_a, slow_byte_b, slow_byte_c
	input  wire                advance,
	output logic               valid_s1,
	output sdma_pkg::frame_t   frame_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			frame_s1 <= sdma_pkg::frame_t'(s_tdata);
		end
	end

endmodule

`default_nettype wire

>>> hdl/sdma_core.sv
// ----------------------------------------------------------------------------
// Slow-data message assembler core
// Sequence state, descrambling and character store. Decides for the held
// frame whether it syncs, advances the step or completes the message.
// ----------------------------------------------------------------------------
`default_nettype none

module sdma_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                fire,
	input  sdma_pkg::frame_t   frame,
	output logic               final_hit,
	output sdma_pkg::msg_t     msg
);

	logic       armed_q;
	logic [3:0] step_q;
	logic [7:0] chars_q [sdma_pkg::StoredChars];

	logic       sync;
	logic       match;
	logic       adv;
	logic [7:0] da;
	logic [7:0] db;
	logic [7:0] dc;
	logic [7:0] marker;

	assign da = frame.slow_byte_a ^ sdma_pkg::KEY_A;
	assign db = frame.slow_byte_b ^ sdma_pkg::KEY_B;
	assign dc = frame.slow_byte_c ^ sdma_pkg::KEY_C;

	assign marker = sdma_pkg::MARK_BASE + {5'd0, step_q[3:1]};

	assign sync = (frame.frame_control == sdma_pkg::FC_SYNC)
		&& (frame.slow_byte_a == sdma_pkg::SYNC_A)
		&& (frame.slow_byte_b == sdma_pkg::SYNC_B)
		&& (frame.slow_byte_c == sdma_pkg::SYNC_C);

	// Odd frames also have to carry the block marker in their first byte.
	assign match = armed_q
		&& (step_q >= sdma_pkg::STEP_FIRST) && (step_q <= sdma_pkg::STEP_LAST)
		&& (frame.frame_control == {4'd0, step_q})
		&& (!step_q[0] || (frame.slow_byte_a == marker));

	assign adv       = !sync && match;
	assign final_hit = adv && (step_q == sdma_pkg::STEP_LAST);

	assign msg.text_low  = {chars_q[7], chars_q[6], chars_q[5], chars_q[4],
	                        chars_q[3], chars_q[2], chars_q[1], chars_q[0]};
	assign msg.text_mid  = {chars_q[15], chars_q[14], chars_q[13], chars_q[12],
	                        chars_q[11], chars_q[10], chars_q[9], chars_q[8]};
	assign msg.text_high = {dc, db, da, chars_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			step_q  <= sdma_pkg::STEP_IDLE;
		end else if (fire) begin
			if (sync) begin
				armed_q <= 1'b1;
				step_q  <= sdma_pkg::STEP_FIRST;
			end else if (final_hit) begin
				armed_q <= 1'b0;
				step_q  <= sdma_pkg::STEP_IDLE;
			end else if (adv) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && adv) begin
			case (step_q)
				sdma_pkg::STEP_FIRST: begin
					chars_q[0] <= db;
					chars_q[1] <= dc;
				end
				sdma_pkg::STEP_2: begin
					chars_q[2] <= da;
					chars_q[3] <= db;
					chars_q[4] <= dc;
				end
				sdma_pkg::STEP_3: begin
					chars_q[5] <= db;
					chars_q[6] <= dc;
				end
				sdma_pkg::STEP_4: begin
					chars_q[7] <= da;
					chars_q[8] <= db;
					chars_q[9] <= dc;
				end
				sdma_pkg::STEP_5: begin
					chars_q[10] <= db;
					chars_q[11] <= dc;
				end
				sdma_pkg::STEP_6: begin
					chars_q[12] <= da;
					chars_q[13] <= db;
					chars_q[14] <= dc;
				end
				sdma_pkg::STEP_7: begin
					chars_q[15] <= db;
					chars_q[16] <= dc;
				end
				default: begin
				end
			endcase
		end
	end

	// The assembler is armed exactly when a step is pending.
	a_armed_step: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q == (step_q != sdma_pkg::STEP_IDLE))
		else $error("armed flag and step disagree");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= sdma_pkg::STEP_LAST)
		else $error("step beyond last frame");

	a_sync_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && sync) |=> (armed_q && step_q == sdma_pkg::STEP_FIRST))
		else $error("sync frame did not restart the sequence");

	a_final_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && final_hit) |=> !armed_q)
		else $error("completed message did not disarm");

endmodule

`default_nettype wire

>>> hdl/sdma_out_reg.sv
// ----------------------------------------------------------------------------
// Slow-data message assembler output register
// Holds one completed message until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sdma_out_reg (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                load,
	input  sdma_pkg::msg_t     msg,
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [159:0]       m_tdata    // text_low, text_mid, text_high
);

	sdma_pkg::msg_t msg_q;

	assign m_tdata = msg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			msg_q <= msg;
		end
	end

endmodule

`default_nettype wire

>>> hdl/slow_data_message_assembler.sv
// ----------------------------------------------------------------------------
// Slow-data message assembler
// Collects the 20-character user text from the slow data of voice frames.
// ----------------------------------------------------------------------------
// The block takes one frame per clock cycle unless the input side stalls. A
// frame passes through an input register and the sequence logic. A completed
// message appears on the master side at the clock edge at which its last frame
// leaves the input register. The output register holds a message until it is
// taken, and frames keep flowing meanwhile. The input side stalls only in one
// case: the frame in the input register would complete a second message while
// the first one is still held and is not taken in that cycle.
// A sync frame (control byte 0, slow data 55 2d 16) arms the sequence; frames
// 1 to 8 must then follow in order.
`default_nettype none

module slow_data_message_assembler (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	input  wire  [31:0]   s_tdata,   // frame_control, slow_byte_a, slow_byte_b, slow_byte_c
	output logic          m_tvalid,
	input  wire           m_tready,
	output logic [159:0]  m_tdata    // text_low, text_mid, text_high
);

	logic             valid_s1;
	sdma_pkg::frame_t frame_s1;
	logic             final_hit;
	logic             fire;
	sdma_pkg::msg_t   msg;

	// A completing frame waits while the output register holds a message that
	// is not taken in this cycle.
	assign fire = valid_s1 && (!final_hit || !m_tvalid || m_tready);

	sdma_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (fire),
		.valid_s1 (valid_s1),
		.frame_s1 (frame_s1)
	);

	sdma_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.frame     (frame_s1),
		.final_hit (final_hit),
		.msg       (msg)
	);

	sdma_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && final_hit),
		.msg      (msg),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

>>> bench/slow_data_message_assembler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slow-data message assembler testbench
// Feeds voice frames into the block and compares every completed message with
// a cycle-free software copy of the assembler. A table of directed frames
// comes first, then well-formed frame sequences with random content, mixed
// with broken sequences and noise, under several patterns of idling.
// ----------------------------------------------------------------------------

module slow_data_message_assembler_tb;

	localparam int RandFrames  = 400;
	localparam int DirRows     = 25;
	localparam int MaxReported = 10;

	typedef struct packed {
		logic [31:0]    frame;
		logic           typed;
		sdma_pkg::msg_t text;
	} dir_row_t;

	// Rows with the typed flag set carry their message; others use the predictor.
	localparam dir_row_t DirTable [DirRows] = '{
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE, 8'd1}, 1'b0, '0},
		'{{sdma_pkg::SYNC_C, sdma_pkg::SYNC_B, sdma_pkg::SYNC_A, sdma_pkg::FC_SYNC},
			1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE, 8'd1}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd1, 8'd3}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::KEY_A, 8'd2}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE, 8'd3}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd1, 8'h43}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd1, 8'd3}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::KEY_A, 8'd4}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd2, 8'd5}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::KEY_A, 8'd6}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd3, 8'd7}, 1'b0, '0},
		'{{sdma_pkg::KEY_C, sdma_pkg::KEY_B, sdma_pkg::KEY_A, 8'd8}, 1'b1, '0},
		'{{sdma_pkg::SYNC_C, sdma_pkg::SYNC_B, sdma_pkg::SYNC_A, sdma_pkg::FC_SYNC},
			1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, sdma_pkg::MARK_BASE, 8'd1}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, ~sdma_pkg::KEY_A, 8'd2}, 1'b0, '0},
		'{{sdma_pkg::SYNC_C, sdma_pkg::SYNC_B, sdma_pkg::SYNC_A, sdma_pkg::FC_SYNC},
			1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, sdma_pkg::MARK_BASE, 8'd1}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, ~sdma_pkg::KEY_A, 8'd2}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd1, 8'd3}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, ~sdma_pkg::KEY_A, 8'd4}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd2, 8'd5}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, ~sdma_pkg::KEY_A, 8'd6}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, sdma_pkg::MARK_BASE + 8'd3, 8'd7}, 1'b0, '0},
		'{{~sdma_pkg::KEY_C, ~sdma_pkg::KEY_B, ~sdma_pkg::KEY_A, 8'd8}, 1'b1, '1}
	};

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  s_tdata = '0;    // frame_control, slow_byte_a, slow_byte_b, slow_byte_c
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;         // text_low, text_mid, text_high

	// Software copy of the assembler state.
	logic       seq_armed = 1'b0;
	logic [3:0] seq_step = sdma_pkg::STEP_IDLE;
	logic [7:0] text_chars [sdma_pkg::StoredChars];

	sdma_pkg::msg_t pending_msgs [$];
	int   mismatches = 0;
	int   frames_used = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;

	slow_data_message_assembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("slow_data_message_assembler_tb: FAIL");
		$finish;
	end

	// Returns 1 when the frame completes a message, with the message in text.
	function automatic bit assemble_frame(input sdma_pkg::frame_t f,
			output sdma_pkg::msg_t text);
		logic [7:0] chars [sdma_pkg::MsgChars];
		int base;
		text = '0;
		if (f.frame_control == sdma_pkg::FC_SYNC && f.slow_byte_a == sdma_pkg::SYNC_A
				&& f.slow_byte_b == sdma_pkg::SYNC_B
				&& f.slow_byte_c == sdma_pkg::SYNC_C) begin
			seq_armed = 1'b1;
			seq_step = sdma_pkg::STEP_FIRST;
			return 1'b0;
		end
		if (!seq_armed || f.frame_control != {4'd0, seq_step})
			return 1'b0;
		base = (seq_step >> 1) * 5;
		if (seq_step[0]) begin
			if (f.slow_byte_a != sdma_pkg::MARK_BASE + 8'(seq_step >> 1))
				return 1'b0;
			text_chars[base] = f.slow_byte_b ^ sdma_pkg::KEY_B;
			text_chars[base + 1] = f.slow_byte_c ^ sdma_pkg::KEY_C;
			seq_step++;
			return 1'b0;
		end
		base = base - 3;
		if (seq_step != sdma_pkg::STEP_LAST) begin
			text_chars[base] = f.slow_byte_a ^ sdma_pkg::KEY_A;
			text_chars[base + 1] = f.slow_byte_b ^ sdma_pkg::KEY_B;
			text_chars[base + 2] = f.slow_byte_c ^ sdma_pkg::KEY_C;
			seq_step++;
			return 1'b0;
		end
		for (int i = 0; i < sdma_pkg::StoredChars; i++)
			chars[i] = text_chars[i];
		chars[sdma_pkg::MsgChars - 3] = f.slow_byte_a ^ sdma_pkg::KEY_A;
		chars[sdma_pkg::MsgChars - 2] = f.slow_byte_b ^ sdma_pkg::KEY_B;
		chars[sdma_pkg::MsgChars - 1] = f.slow_byte_c ^ sdma_pkg::KEY_C;
		seq_armed = 1'b0;
		seq_step = sdma_pkg::STEP_IDLE;
		for (int i = 0; i < 8; i++) begin
			text.text_low[8 * i +: 8] = chars[i];
			text.text_mid[8 * i +: 8] = chars[8 + i];
		end
		for (int i = 0; i < 4; i++)
			text.text_high[8 * i +: 8] = chars[16 + i];
		return 1'b1;
	endfunction

	// Called and left at a falling edge. The valid stays high between
	// back-to-back items and is lowered only when a gap is chosen.
	task automatic put_frame(input sdma_pkg::frame_t f, input bit typed,
			input sdma_pkg::msg_t typed_text);
		bit             done;
		sdma_pkg::msg_t text;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= f;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		done = assemble_frame(f, text);
		frames_used++;
		if (typed) begin
			pending_msgs.push_back(typed_text);
		end else if (done) begin
			pending_msgs.push_back(text);
		end
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= MaxReported)
			$display("%0t: %s: expected %h, got %h", $time, what, want, got);
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : check_msgs
		sdma_pkg::msg_t got;
		sdma_pkg::msg_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_msgs.size() == 0) begin
				note_mismatch("message with none pending, text_low", '0, got.text_low);
			end else begin
				want = pending_msgs.pop_front();
				if (got.text_low !== want.text_low)
					note_mismatch("text_low", want.text_low, got.text_low);
				if (got.text_mid !== want.text_mid)
					note_mismatch("text_mid", want.text_mid, got.text_mid);
				if (got.text_high !== want.text_high)
					note_mismatch("text_high", {32'd0, want.text_high}, {32'd0, got.text_high});
			end
		end
	end

	initial begin : stimulus
		sdma_pkg::frame_t f;
		int     pick;
		int     last;
		for (int i = 0; i < sdma_pkg::StoredChars; i++)
			text_chars[i] = 8'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DirRows; r++)
			put_frame(DirTable[r].frame, DirTable[r].typed, DirTable[r].text);

		frames_used = 0;
		while (frames_used < RandFrames) begin
			case (frames_used * 4 / RandFrames)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 59;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			pick = $urandom_range(99);
			if (pick < 75) begin
				// A sequence from sync onward, complete most of the time.
				last = (pick < 60) ? 8 : $urandom_range(1, 7);
				put_frame({sdma_pkg::SYNC_C, sdma_pkg::SYNC_B, sdma_pkg::SYNC_A,
					sdma_pkg::FC_SYNC}, 1'b0, '0);
				for (int s = 1; s <= last; s++) begin
					if ($urandom_range(99) < 4) begin
						f = $urandom;
						f.frame_control = 8'($urandom_range(0, 15));
						put_frame(f, 1'b0, '0);
					end
					f = $urandom;
					f.frame_control = 8'(s);
					if (s % 2 == 1 && $urandom_range(99) >= 3)
						f.slow_byte_a = sdma_pkg::MARK_BASE + 8'(s / 2);
					put_frame(f, 1'b0, '0);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					f = $urandom;
					if ($urandom_range(1))
						f.frame_control = 8'($urandom_range(0, 15));
					// Sync bytes under a control byte that may or may not be zero.
					if ($urandom_range(9) == 0) begin
						f.slow_byte_a = sdma_pkg::SYNC_A;
						f.slow_byte_b = sdma_pkg::SYNC_B;
						f.slow_byte_c = sdma_pkg::SYNC_C;
					end
					put_frame(f, 1'b0, '0);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_msgs.size() == 0) begin
			$display("slow_data_message_assembler_tb: PASS");
		end else begin
			$display("slow_data_message_assembler_tb: FAIL");
		end
		$finish;
	end

endmodule
